@@ rtl/ctlm_pkg.sv @@
// ----------------------------------------------------------------------------
// ctlm_pkg
// types and constants shared by the codepoint trie longest match block
// ----------------------------------------------------------------------------
package ctlm_pkg;

   localparam int NODE_SLOTS  = 1024;
   localparam int ENTRY_SLOTS = 256;
   localparam int NODE_W      = $clog2(NODE_SLOTS);
   localparam int COUNT_W     = NODE_W + 1;
   localparam int EADDR_W     = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;
   localparam int ENTRY_W     = 9;
   localparam int CODE_W      = 21;
   localparam int BYTES_W     = 12;
   localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_MATCH  = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_FOUND    = 2'd0,
      ST_REPLACED = 2'd1,
      ST_MISSING  = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [CODE_W-1:0] codepoint;
      logic [2:0]        code_bytes;
      logic              last;
      logic              text_default;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [ENTRY_W-1:0] entry_id;
      logic [BYTES_W-1:0] matched_bytes;
      logic               entry_flag;
   } rsp_type;

   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [NODE_W-1:0]  first_child;
      logic [NODE_W-1:0]  next_sibling;
      logic [ENTRY_W-1:0] entry;
   } node_type;

endpackage

@@ rtl/ctlm_req_if.sv @@
// ----------------------------------------------------------------------------
// ctlm_req_if
// valid/ready channel carrying one request item
// ----------------------------------------------------------------------------
interface ctlm_req_if;
   logic                 valid;
   logic                 ready;
   ctlm_pkg::req_type    data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/ctlm_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ctlm_rsp_if
// valid/ready channel carrying one result item
// ----------------------------------------------------------------------------
interface ctlm_rsp_if;
   logic                 valid;
   logic                 ready;
   ctlm_pkg::rsp_type    data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/ctlm_ram.sv @@
// ----------------------------------------------------------------------------
// ctlm_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ctlm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/codepoint_trie_longest_match.sv @@
// ----------------------------------------------------------------------------
// codepoint_trie_longest_match
// trie of codepoint sequences with insert and longest prefix match
// ----------------------------------------------------------------------------
// items arrive on req_ch one decoded codepoint each; op selects insert, match
// or clear. the last insert or match item of a sequence gives one result item on rsp_ch.
// nodes live in a 1024 x 50 node ram (code, first child, next sibling, entry)
// and entry flags in a 256 x 1 ram, both with a registered read port.
// one item is taken at a time: req_ch.ready is high only while idle.
// an item reads the node ram in S_LOOK and compares siblings in turn in
// S_CMP; a missing child goes to S_MISS and a new node is linked in S_LINK.
// S_FIN sets up the result of a last item, and S_FLAG reads the flag of a match
// that found an entry. an item after a dead walk or a full store skips to
// S_FIN; a clear or unused op stays idle. the sibling scan sets the rate.
// the result waits in an output register; while rsp_ch is stalled the
// block still takes and walks items and holds only before a further result.
// reset (synchronous) empties the trie and walk state, no sweep.
// ----------------------------------------------------------------------------
module codepoint_trie_longest_match (
   input  logic        clock,
   input  logic        reset,
   ctlm_req_if.sink    req_ch,
   ctlm_rsp_if.source  rsp_ch
);
   import ctlm_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_LOOK = 8'b0000_0010,
      S_CMP  = 8'b0000_0100,
      S_MISS = 8'b0000_1000,
      S_LINK = 8'b0001_0000,
      S_FIN  = 8'b0010_0000,
      S_FLAG = 8'b0100_0000,
      S_OUT  = 8'b1000_0000
   } state_type;

   localparam logic [COUNT_W-1:0] NODE_LIMIT  = COUNT_W'(NODE_SLOTS);
   localparam logic [ENTRY_W-1:0] ENTRY_LIMIT = ENTRY_W'(ENTRY_SLOTS);

   state_type             state_ff, state_in;
   req_type               item_ff, item_in;
   node_type              cur_ff, cur_in;
   logic [NODE_W-1:0]     cursor_ff, cursor_in;
   logic [NODE_W-1:0]     ptr_ff, ptr_in;
   logic [NODE_W-1:0]     root_fc_ff, root_fc_in;
   logic [COUNT_W-1:0]    ncount_ff, ncount_in;
   logic [ENTRY_W-1:0]    ecount_ff, ecount_in;
   logic                  dead_ff, dead_in;
   logic                  full_ff, full_in;
   logic [ENTRY_W-1:0]    best_ff, best_in;
   logic [BYTES_W-1:0]    consumed_ff, consumed_in;
   logic [BYTES_W-1:0]    best_bytes_ff, best_bytes_in;
   rsp_type               res_ff, res_in;
   rsp_type               out_ff, out_in;
   logic                  out_valid_ff, out_valid_in;

   logic                  node_we;
   logic [NODE_W-1:0]     node_waddr, node_raddr;
   node_type              node_wdata, node_rdata;
   logic                  flag_we, flag_wdata, flag_rdata;
   logic [EADDR_W-1:0]    flag_waddr, flag_raddr;
   logic [BYTES_W:0]      sum;
   logic                  accept;

   ctlm_ram #(.WIDTH($bits(node_type)), .DEPTH(NODE_SLOTS)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_waddr),
      .wr_data (node_wdata),
      .rd_addr (node_raddr),
      .rd_data (node_rdata)
   );

   ctlm_ram #(.WIDTH(1), .DEPTH(ENTRY_SLOTS)) u_flag_ram (
      .clock   (clock),
      .wr_en   (flag_we),
      .wr_addr (flag_waddr),
      .wr_data (flag_wdata),
      .rd_addr (flag_raddr),
      .rd_data (flag_rdata)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.data  = out_ff;
   assign sum          = {1'b0, consumed_ff} + (BYTES_W+1)'(item_ff.code_bytes);

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      cur_in        = cur_ff;
      cursor_in     = cursor_ff;
      ptr_in        = ptr_ff;
      root_fc_in    = root_fc_ff;
      ncount_in     = ncount_ff;
      ecount_in     = ecount_ff;
      dead_in       = dead_ff;
      full_in       = full_ff;
      best_in       = best_ff;
      consumed_in   = consumed_ff;
      best_bytes_in = best_bytes_ff;
      res_in        = res_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      node_we       = 1'b0;
      node_waddr    = cursor_ff;
      node_wdata    = cur_ff;
      node_raddr    = ptr_ff;
      flag_we       = 1'b0;
      flag_waddr    = EADDR_W'(best_ff - 1'b1);
      flag_wdata    = item_ff.text_default;
      flag_raddr    = EADDR_W'(best_ff - 1'b1);

      if (out_valid_ff && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in = req_ch.data;
               ptr_in  = (cursor_ff == '0) ? root_fc_ff : cur_ff.first_child;
               unique case (op_type'(req_ch.data.op))
                  OP_CLEAR: begin
                     root_fc_in    = '0;
                     ncount_in     = COUNT_W'(1);
                     ecount_in     = '0;
                     cursor_in     = '0;
                     cur_in        = '0;
                     dead_in       = 1'b0;
                     full_in       = 1'b0;
                     best_in       = '0;
                     consumed_in   = '0;
                     best_bytes_in = '0;
                  end
                  OP_INSERT: state_in = full_ff ? S_FIN : S_LOOK;
                  OP_MATCH:  state_in = dead_ff ? S_FIN : S_LOOK;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_LOOK: begin
            node_raddr = ptr_ff;
            state_in   = (ptr_ff == '0) ? S_MISS : S_CMP;
         end
         S_CMP: begin
            if (node_rdata.code == item_ff.codepoint) begin
               cursor_in = ptr_ff;
               cur_in    = node_rdata;
               if (item_ff.op == OP_MATCH) begin
                  consumed_in = sum[BYTES_W] ? BYTES_MAX : sum[BYTES_W-1:0];
                  if (node_rdata.entry != '0) begin
                     best_in       = node_rdata.entry;
                     best_bytes_in = sum[BYTES_W] ? BYTES_MAX : sum[BYTES_W-1:0];
                  end
               end
               state_in = S_FIN;
            end else if (node_rdata.next_sibling == '0) begin
               state_in = S_MISS;
            end else begin
               ptr_in     = node_rdata.next_sibling;
               node_raddr = node_rdata.next_sibling;
            end
         end
         S_MISS: begin
            if (item_ff.op == OP_MATCH) begin
               dead_in  = 1'b1;
               state_in = S_FIN;
            end else if (ncount_ff < NODE_LIMIT) begin
               node_we    = 1'b1;
               node_waddr = ncount_ff[NODE_W-1:0];
               node_wdata = '{code: item_ff.codepoint, first_child: '0,
                              next_sibling: (cursor_ff == '0) ? root_fc_ff
                                                              : cur_ff.first_child,
                              entry: '0};
               state_in   = S_LINK;
            end else begin
               full_in  = 1'b1;
               state_in = S_FIN;
            end
         end
         S_LINK: begin
            if (cursor_ff == '0) begin
               root_fc_in = ncount_ff[NODE_W-1:0];
            end else begin
               node_we                = 1'b1;
               node_wdata             = cur_ff;
               node_wdata.first_child = ncount_ff[NODE_W-1:0];
            end
            cur_in    = '{code: item_ff.codepoint, first_child: '0,
                          next_sibling: (cursor_ff == '0) ? root_fc_ff
                                                          : cur_ff.first_child,
                          entry: '0};
            cursor_in = ncount_ff[NODE_W-1:0];
            ncount_in = ncount_ff + 1'b1;
            state_in  = S_FIN;
         end
         S_FIN: begin
            if (!item_ff.last) begin
               state_in = S_IDLE;
            end else if (item_ff.op == OP_INSERT) begin
               state_in = S_OUT;
               res_in   = '{status: ST_FULL, entry_id: '0, matched_bytes: '0,
                            entry_flag: 1'b0};
               if (!full_ff) begin
                  if (cur_ff.entry != '0) begin
                     flag_we    = 1'b1;
                     flag_waddr = EADDR_W'(cur_ff.entry - 1'b1);
                     res_in     = '{status: ST_REPLACED, entry_id: cur_ff.entry,
                                    matched_bytes: '0,
                                    entry_flag: item_ff.text_default};
                  end else if (ecount_ff < ENTRY_LIMIT) begin
                     flag_we          = 1'b1;
                     flag_waddr       = EADDR_W'(ecount_ff);
                     node_we          = 1'b1;
                     node_wdata       = cur_ff;
                     node_wdata.entry = ecount_ff + 1'b1;
                     ecount_in        = ecount_ff + 1'b1;
                     res_in           = '{status: ST_FOUND, entry_id: ecount_ff + 1'b1,
                                          matched_bytes: '0,
                                          entry_flag: item_ff.text_default};
                  end
               end
            end else if (best_ff != '0) begin
               state_in = S_FLAG;
            end else begin
               res_in   = '{status: ST_MISSING, entry_id: '0, matched_bytes: '0,
                            entry_flag: 1'b0};
               state_in = S_OUT;
            end
         end
         S_FLAG: begin
            res_in   = '{status: ST_FOUND, entry_id: best_ff,
                         matched_bytes: best_bytes_ff, entry_flag: flag_rdata};
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_in        = res_ff;
               out_valid_in  = 1'b1;
               cursor_in     = '0;
               cur_in        = '0;
               dead_in       = 1'b0;
               full_in       = 1'b0;
               best_in       = '0;
               consumed_in   = '0;
               best_bytes_in = '0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cursor_ff     <= '0;
         cur_ff        <= '0;
         root_fc_ff    <= '0;
         ncount_ff     <= COUNT_W'(1);
         ecount_ff     <= '0;
         dead_ff       <= 1'b0;
         full_ff       <= 1'b0;
         best_ff       <= '0;
         consumed_ff   <= '0;
         best_bytes_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_ff     <= cursor_in;
         cur_ff        <= cur_in;
         root_fc_ff    <= root_fc_in;
         ncount_ff     <= ncount_in;
         ecount_ff     <= ecount_in;
         dead_ff       <= dead_in;
         full_ff       <= full_in;
         best_ff       <= best_in;
         consumed_ff   <= consumed_in;
         best_bytes_ff <= best_bytes_in;
         out_valid_ff  <= out_valid_in;
      end
      item_ff <= item_in;
      ptr_ff  <= ptr_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside output step");

   a_node_count: assert property (@(posedge clock) disable iff (reset)
      ncount_ff != '0 && ncount_ff <= NODE_LIMIT)
      else $error("node count out of range");

   a_entry_count: assert property (@(posedge clock) disable iff (reset)
      ecount_ff <= ENTRY_LIMIT)
      else $error("entry count out of range");

   a_best_in_range: assert property (@(posedge clock) disable iff (reset)
      best_ff <= ecount_ff)
      else $error("best entry beyond allocated entries");

endmodule

@@ tb/sv/codepoint_trie_longest_match_tb.sv @@
// ----------------------------------------------------------------------------
// codepoint_trie_longest_match_tb
// self-checking bench for the codepoint trie with longest prefix match
// ----------------------------------------------------------------------------
// a directed table covers empty lookups, the widest codepoint, replacement,
// dead walks, clear and the unused op, followed by fill passes for a full
// entry store and a full node store. random sequences over a small alphabet
// follow. every accepted request item updates a local trie model whose
// result, or a pinned one given with the item, is queued and compared with the rsp_ch item stream.
// both channels idle at random, apart from one long calm stretch.
// ----------------------------------------------------------------------------
module codepoint_trie_longest_match_tb;
   import ctlm_pkg::*;

   typedef struct {
      op_type       op;
      logic [20:0]  cp;
      logic [2:0]   nb;
      bit           last;
      bit           tdef;
      bit           pinned;
      rsp_type      want;
   } row_type;

   typedef struct {
      bit      pinned;
      rsp_type want;
   } pin_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ctlm_req_if req_ch ();
   ctlm_rsp_if rsp_ch ();

   codepoint_trie_longest_match u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // trie model
   logic [20:0] t_code [NODE_SLOTS];
   logic [9:0]  t_child [NODE_SLOTS];
   logic [9:0]  t_sib [NODE_SLOTS];
   logic [8:0]  t_entry [NODE_SLOTS];
   bit          t_flag [ENTRY_SLOTS];
   logic [9:0]  t_root;
   int          t_nodes;
   int          t_entries;
   logic [9:0]  t_cur;
   bit          t_dead;
   logic [8:0]  t_best;
   int          t_used;
   int          t_best_bytes;
   bit          t_full;

   rsp_type     result_q [$];
   pin_type     pin_q [$];
   int          errors = 0;
   int          sent = 0;
   int          results_seen = 0;
   bit          req_taken = 1'b0;
   bit          calm = 1'b0;

   function automatic void walk_clear();
      t_cur = '0; t_dead = 0; t_best = '0; t_used = 0; t_best_bytes = 0; t_full = 0;
   endfunction

   function automatic void trie_clear();
      t_root = '0; t_nodes = 1; t_entries = 0;
      walk_clear();
   endfunction

   function automatic logic [9:0] first_of(logic [9:0] p);
      return (p == 0) ? t_root : t_child[p];
   endfunction

   function automatic logic [9:0] find_child(logic [9:0] p, logic [20:0] cp);
      logic [9:0] n;
      int guard;
      n = first_of(p);
      guard = 0;
      while (n != 0 && guard < NODE_SLOTS) begin
         if (t_code[n] == cp) return n;
         n = t_sib[n];
         guard++;
      end
      return '0;
   endfunction

   function automatic bit trie_step(input req_type r, output rsp_type o);
      logic [9:0] n;
      logic [8:0] e;
      o = '0;
      if (r.op == OP_CLEAR) begin
         trie_clear();
         return 0;
      end
      if (r.op == OP_NONE) return 0;
      if (r.op == OP_INSERT) begin
         if (!t_full) begin
            n = find_child(t_cur, r.codepoint);
            if (n == 0) begin
               if (t_nodes < NODE_SLOTS) begin
                  n = t_nodes[9:0];
                  t_nodes++;
                  t_code[n] = r.codepoint;
                  t_child[n] = '0;
                  t_sib[n] = first_of(t_cur);
                  t_entry[n] = '0;
                  if (t_cur == 0) t_root = n;
                  else t_child[t_cur] = n;
                  t_cur = n;
               end else begin
                  t_full = 1;
               end
            end else begin
               t_cur = n;
            end
         end
         if (!r.last) return 0;
         if (t_full) begin
            o.status = ST_FULL;
         end else begin
            e = t_entry[t_cur];
            if (e != 0) begin
               t_flag[e - 1] = r.text_default;
               o.status = ST_REPLACED; o.entry_id = e; o.entry_flag = r.text_default;
            end else if (t_entries < ENTRY_SLOTS) begin
               t_entries++;
               t_flag[t_entries - 1] = r.text_default;
               t_entry[t_cur] = t_entries[8:0];
               o.status = ST_FOUND; o.entry_id = t_entries[8:0];
               o.entry_flag = r.text_default;
            end else begin
               o.status = ST_FULL;
            end
         end
         walk_clear();
         return 1;
      end
      if (!t_dead) begin
         n = find_child(t_cur, r.codepoint);
         if (n == 0) begin
            t_dead = 1;
         end else begin
            t_cur = n;
            t_used += r.code_bytes;
            if (t_used > BYTES_MAX) t_used = BYTES_MAX;
            if (t_entry[n] != 0) begin
               t_best = t_entry[n];
               t_best_bytes = t_used;
            end
         end
      end
      if (!r.last) return 0;
      if (t_best != 0) begin
         o.status = ST_FOUND; o.entry_id = t_best;
         o.matched_bytes = t_best_bytes[11:0]; o.entry_flag = t_flag[t_best - 1];
      end else begin
         o.status = ST_MISSING;
      end
      walk_clear();
      return 1;
   endfunction

   // acceptance and result checking
   always @(posedge clock) begin
      rsp_type o;
      pin_type p;
      req_taken = req_ch.valid && req_ch.ready && !reset;
      if (req_taken) begin
         p = pin_q.pop_front();
         if (trie_step(req_ch.data, o)) result_q.push_back(p.pinned ? p.want : o);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (result_q.size() == 0) begin
            $display("%0t: unexpected result item %p", $time, rsp_ch.data);
            errors++;
         end else begin
            o = result_q.pop_front();
            if (rsp_ch.data.status !== o.status)
               $display("%0t: status expected %0d actual %0d", $time, o.status,
                        rsp_ch.data.status);
            if (rsp_ch.data.entry_id !== o.entry_id)
               $display("%0t: entry_id expected %0d actual %0d", $time, o.entry_id,
                        rsp_ch.data.entry_id);
            if (rsp_ch.data.matched_bytes !== o.matched_bytes)
               $display("%0t: matched_bytes expected %0d actual %0d", $time,
                        o.matched_bytes, rsp_ch.data.matched_bytes);
            if (rsp_ch.data.entry_flag !== o.entry_flag)
               $display("%0t: entry_flag expected %0d actual %0d", $time, o.entry_flag,
                        rsp_ch.data.entry_flag);
            if (rsp_ch.data !== o) errors++;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready = reset ? 1'b0 : (calm || $urandom_range(0, 99) >= 13);
   end

   task automatic send(input op_type op, input logic [20:0] cp, input logic [2:0] nb,
                       input bit last, input bit tdef, input bit pinned = 0,
                       input rsp_type want = '0);
      req_type r;
      pin_type p;
      r.op = op; r.codepoint = cp; r.code_bytes = nb; r.last = last; r.text_default = tdef;
      while (!calm && $urandom_range(0, 99) < 13) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      p.pinned = pinned; p.want = want;
      pin_q.push_back(p);
      req_ch.valid = 1'b1;
      req_ch.data = r;
      do @(negedge clock); while (!req_taken);
      req_ch.valid = 1'b0;
      sent++;
   endtask

   row_type dir_rows [] = '{
      '{OP_MATCH,  21'h000000, 3'd1, 1, 0, 1, '{ST_MISSING, 9'd0, 12'd0, 1'b0}},
      '{OP_INSERT, 21'h1FFFFF, 3'd7, 1, 1, 1, '{ST_FOUND, 9'd1, 12'd0, 1'b1}},
      '{OP_INSERT, 21'h1FFFFF, 3'd0, 1, 0, 1, '{ST_REPLACED, 9'd1, 12'd0, 1'b0}},
      '{OP_MATCH,  21'h1FFFFF, 3'd7, 1, 1, 1, '{ST_FOUND, 9'd1, 12'd7, 1'b0}},
      '{OP_INSERT, 21'h01F600, 3'd4, 0, 0, 0, '0},
      '{OP_INSERT, 21'h00200D, 3'd3, 0, 1, 0, '0},
      '{OP_INSERT, 21'h002764, 3'd3, 1, 1, 0, '0},
      '{OP_INSERT, 21'h01F600, 3'd4, 1, 0, 0, '0},
      '{OP_MATCH,  21'h01F600, 3'd4, 0, 0, 0, '0},
      '{OP_MATCH,  21'h00200D, 3'd3, 0, 0, 0, '0},
      '{OP_MATCH,  21'h000041, 3'd1, 0, 0, 0, '0},
      '{OP_MATCH,  21'h002764, 3'd5, 1, 0, 0, '0},
      '{OP_MATCH,  21'h000000, 3'd0, 1, 0, 1, '{ST_MISSING, 9'd0, 12'd0, 1'b0}},
      '{OP_NONE,   21'h1FFFFF, 3'd7, 1, 1, 0, '0},
      '{OP_INSERT, 21'h000041, 3'd6, 0, 1, 0, '0},
      '{OP_MATCH,  21'h000042, 3'd2, 1, 0, 0, '0},
      '{OP_INSERT, 21'h000041, 3'd1, 0, 0, 0, '0},
      '{OP_CLEAR,  21'h1FFFFF, 3'd7, 1, 1, 0, '0},
      '{OP_MATCH,  21'h01F600, 3'd4, 1, 0, 1, '{ST_MISSING, 9'd0, 12'd0, 1'b0}},
      '{OP_INSERT, 21'h000000, 3'd1, 1, 0, 1, '{ST_FOUND, 9'd1, 12'd0, 1'b0}}
   };

   initial begin
      logic [20:0] alpha [8];
      int len;
      int kind;
      int seqs;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      trie_clear();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i])
         send(dir_rows[i].op, dir_rows[i].cp, dir_rows[i].nb, dir_rows[i].last,
              dir_rows[i].tdef, dir_rows[i].pinned, dir_rows[i].want);

      // fill the entry store, then overflow it
      send(OP_CLEAR, 21'h0, 3'd1, 0, 0);
      for (int i = 0; i < ENTRY_SLOTS; i++)
         send(OP_INSERT, 21'('h100 + i), 3'd2, 1, i[0]);
      send(OP_INSERT, 21'h5000, 3'd2, 1, 1, 1, '{ST_FULL, 9'd0, 12'd0, 1'b0});
      // run out of nodes in the middle of a sequence
      for (int i = 0; i < 780; i++)
         send(OP_INSERT, 21'('h6000 + i), 3'd1, 0, 0);
      send(OP_INSERT, 21'h7000, 3'd1, 1, 1, 1, '{ST_FULL, 9'd0, 12'd0, 1'b0});
      send(OP_CLEAR, 21'h0, 3'd1, 0, 0);

      foreach (alpha[i]) alpha[i] = 21'($urandom_range(0, 21'h1FFFFF));
      alpha[0] = 21'h000000;
      alpha[1] = 21'h1FFFFF;
      seqs = 0;
      for (int start = sent; sent < start + 190; ) begin
         calm = (sent - start) > 60 && (sent - start) < 140;
         kind = $urandom_range(0, 99);
         len = $urandom_range(1, 5);
         seqs++;
         if (seqs % 25 == 0) begin
            send(OP_CLEAR, 21'($urandom_range(0, 21'h1FFFFF)), 3'($urandom_range(0, 7)),
                 0, 0);
         end else if (kind < 3) begin
            send(OP_NONE, 21'($urandom_range(0, 21'h1FFFFF)), 3'($urandom_range(0, 7)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            for (int k = 0; k < len; k++)
               send(kind < 8 ? op_type'($urandom_range(0, 1)) :
                    (kind < 55 ? OP_INSERT : OP_MATCH),
                    (kind < 12) ? 21'($urandom_range(0, 21'h1FFFFF))
                                : alpha[3'($urandom_range(0, 7))],
                    3'($urandom_range(0, 7)), k == len - 1, 1'($urandom_range(0, 1)));
         end
      end
      calm = 1'b0;

      fork
         wait (result_q.size() == 0);
         repeat (200000) @(posedge clock);
      join_any
      disable fork;
      repeat (40) @(posedge clock);
      $display("sent %0d request items, checked %0d result items", sent, results_seen);
      $display("covered full stores, replacement, dead walks and random sequences");
      if (errors == 0 && result_q.size() == 0) begin
         $display("codepoint_trie_longest_match_tb: clean");
      end else begin
         $display("codepoint_trie_longest_match_tb: errors");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("codepoint_trie_longest_match_tb: errors");
      $finish;
   end

endmodule
